@@ rtl/core/rmsf_pkg.sv @@
// Package for the range median smoothing filter.
// Holds widths, reset values, register indexes and divide-by-ten constants.
// No dependencies; every other file uses it by scoped names.
package rmsf_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 4;
    localparam int RUN_W    = 8;
    localparam int CFG_W    = 16;

    // Default window length of the median ring
    localparam int WINDOW_DEFAULT = 3;

    // Configuration register indexes
    localparam logic REG_RANGE_LIMIT = 1'b0;
    localparam logic REG_WEIGHT      = 1'b1;

    // Configuration reset values
    localparam logic [SAMPLE_W-1:0] RANGE_LIMIT_RESET = 16'd600;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET      = 4'd9;

    // Full weight of the blend, in tenths
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 4'd10;

    // Saturation point of the invalid-run counter
    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    // Blend sum: at most 10 * 65535, fits 20 bits
    localparam int SUM_W = 20;

    // floor(x / 10) = (x * DIV10_MULT) >> DIV10_SHIFT, exact for x < 2^22
    localparam int                 DIV10_SHIFT = 23;
    localparam logic [SUM_W-1:0]   DIV10_MULT  = 20'd838861;

endpackage

@@ rtl/core/rmsf_if.sv @@
// Valid/ready channel interfaces for samples and filter results.
// Depends on rmsf_pkg for field widths.
interface rmsf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [rmsf_pkg::SAMPLE_W-1:0] sample_mm;
    logic                          timed_out;

    modport source (output valid, output sample_mm, output timed_out, input ready);
    modport sink   (input valid, input sample_mm, input timed_out, output ready);
endinterface

interface rmsf_result_if;
    logic                          valid;
    logic                          ready;
    logic [rmsf_pkg::SAMPLE_W-1:0] filtered_mm;
    logic                          sample_used;
    logic                          was_cleared;

    modport source (output valid, output filtered_mm, output sample_used,
                    output was_cleared, input ready);
    modport sink   (input valid, input filtered_mm, input sample_used,
                    input was_cleared, output ready);
endinterface

@@ rtl/core/range_median_smoothing_filter_core.sv @@
// Range median smoothing filter core: input register, one compute pass, result register.
// Input register, then result register; one sample per cycle while results are taken,
// set by the state update loop (ring write, median, blend, divide by ten).
// Reset: ring, smoothed value, slot and invalid run go to zero; range limit to 600,
// weight to 9 tenths. No clearing pass; the block accepts samples right after reset.
// Depends on rmsf_pkg, rmsf_if, rmsf_median and rmsf_blend.
module range_median_smoothing_filter_core #(
    parameter int WINDOW = rmsf_pkg::WINDOW_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rmsf_sample_if.sink                sample_ch,
    rmsf_result_if.source              result_ch,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [rmsf_pkg::CFG_W-1:0] cfg_data
);
    localparam int                SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW - 1);
    localparam logic [rmsf_pkg::RUN_W-1:0] RUN_CLEAR = rmsf_pkg::RUN_W'(WINDOW);

    // Configuration registers
    logic [rmsf_pkg::SAMPLE_W-1:0] range_limit_reg;
    logic [rmsf_pkg::WEIGHT_W-1:0] weight_reg;

    // Input stage
    logic                          in_valid_reg;
    logic [rmsf_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                          in_timeout_reg;

    // Filter state
    logic [rmsf_pkg::SAMPLE_W-1:0] ring_reg  [WINDOW];
    logic [rmsf_pkg::SAMPLE_W-1:0] ring_next [WINDOW];
    logic [rmsf_pkg::SAMPLE_W-1:0] ring_wr   [WINDOW];
    logic [SLOT_W-1:0]             slot_reg;
    logic [SLOT_W-1:0]             slot_next;
    logic [rmsf_pkg::RUN_W-1:0]    run_reg;
    logic [rmsf_pkg::RUN_W-1:0]    run_next;
    logic [rmsf_pkg::SAMPLE_W-1:0] smoothed_reg;
    logic [rmsf_pkg::SAMPLE_W-1:0] smoothed_next;

    // Result stage
    logic                          out_valid_reg;
    logic [rmsf_pkg::SAMPLE_W-1:0] out_filtered_reg;
    logic                          out_used_reg;
    logic                          out_cleared_reg;

    logic                          advance;
    logic                          is_invalid;
    logic                          used;
    logic                          cleared;
    logic [SLOT_W-1:0]             slot_eff;
    logic [rmsf_pkg::SAMPLE_W-1:0] median;
    logic [rmsf_pkg::SAMPLE_W-1:0] blended;

    // Handshake: input stage moves on when the result register is free or being taken
    assign advance         = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= rmsf_pkg::RANGE_LIMIT_RESET;
            weight_reg      <= rmsf_pkg::WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rmsf_pkg::REG_RANGE_LIMIT: range_limit_reg <= cfg_data;
                rmsf_pkg::REG_WEIGHT:      weight_reg      <= cfg_data[rmsf_pkg::WEIGHT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            in_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            in_sample_reg  <= sample_ch.sample_mm;
            in_timeout_reg <= sample_ch.timed_out;
        end
    end

    // Classification and ring write
    assign is_invalid = (in_sample_reg == '0) || (in_sample_reg >= range_limit_reg)
                      || in_timeout_reg;
    assign slot_eff   = (slot_reg > SLOT_TOP) ? '0 : slot_reg;

    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            ring_wr[i] = (slot_eff == SLOT_W'(i)) ? in_sample_reg : ring_reg[i];
        end
    end

    rmsf_median #(
        .WINDOW (WINDOW)
    ) u_median (
        .ring   (ring_wr),
        .median (median)
    );

    rmsf_blend u_blend (
        .median   (median),
        .smoothed (smoothed_reg),
        .weight   (weight_reg),
        .blended  (blended)
    );

    // Next state
    always_comb
    begin
        used          = 1'b0;
        cleared       = 1'b0;
        run_next      = run_reg;
        slot_next     = slot_reg;
        smoothed_next = smoothed_reg;
        ring_next     = ring_reg;
        if (is_invalid)
        begin
            if (run_reg != rmsf_pkg::RUN_MAX)
            begin
                run_next = run_reg + 1'b1;
            end
            if (run_next >= RUN_CLEAR)
            begin
                cleared       = 1'b1;
                smoothed_next = '0;
                for (int i = 0; i < WINDOW; i++)
                begin
                    ring_next[i] = '0;
                end
            end
        end
        else
        begin
            used          = 1'b1;
            run_next      = '0;
            ring_next     = ring_wr;
            slot_next     = (slot_eff == SLOT_TOP) ? '0 : slot_eff + 1'b1;
            smoothed_next = blended;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            run_reg      <= '0;
            smoothed_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            slot_reg     <= slot_next;
            run_reg      <= run_next;
            smoothed_reg <= smoothed_next;
            ring_reg     <= ring_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_filtered_reg <= smoothed_next;
            out_used_reg     <= used;
            out_cleared_reg  <= cleared;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.filtered_mm = out_filtered_reg;
    assign result_ch.sample_used = out_used_reg;
    assign result_ch.was_cleared = out_cleared_reg;

    // Assertions
    a_used_xor_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> !(result_ch.sample_used && result_ch.was_cleared))
        else $error("result marks a sample both used and cleared");

    a_cleared_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.was_cleared) |-> (result_ch.filtered_mm == '0))
        else $error("cleared result carries a nonzero filtered value");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result_ch.ready) |-> !sample_ch.ready)
        else $error("sample accepted while both stages are full and stalled");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (slot_reg <= SLOT_TOP))
        else $error("write slot left the ring");
endmodule

@@ rtl/core/rmsf_median.sv @@
// Median of the sample ring by parallel rank counting.
// Depends on rmsf_pkg; instantiated by the filter core.
module rmsf_median #(
    parameter int WINDOW = rmsf_pkg::WINDOW_DEFAULT
) (
    input  logic [rmsf_pkg::SAMPLE_W-1:0] ring [WINDOW],
    output logic [rmsf_pkg::SAMPLE_W-1:0] median
);
    localparam int                RANK_W = $clog2(WINDOW);
    localparam logic [RANK_W-1:0] MID    = RANK_W'(WINDOW / 2);

    // Each entry's sorted position: smaller entries, ties broken by index.
    // The entry whose position is the middle one is the median.
    always_comb
    begin
        logic [RANK_W-1:0] rank;
        median = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            rank = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if ((ring[j] < ring[i]) || ((ring[j] == ring[i]) && (j < i)))
                begin
                    rank = rank + 1'b1;
                end
            end
            if (rank == MID)
            begin
                median = median | ring[i];
            end
        end
    end
endmodule

@@ rtl/core/rmsf_blend.sv @@
// Exponential blend of the new median into the smoothed value, in tenths.
// Depends on rmsf_pkg; instantiated by the filter core.
module rmsf_blend (
    input  logic [rmsf_pkg::SAMPLE_W-1:0] median,
    input  logic [rmsf_pkg::SAMPLE_W-1:0] smoothed,
    input  logic [rmsf_pkg::WEIGHT_W-1:0] weight,
    output logic [rmsf_pkg::SAMPLE_W-1:0] blended
);
    logic [rmsf_pkg::WEIGHT_W-1:0]  w_new;
    logic [rmsf_pkg::WEIGHT_W-1:0]  w_old;
    logic [rmsf_pkg::SUM_W-1:0]     sum;
    logic [2*rmsf_pkg::SUM_W-1:0]   prod;
    logic [rmsf_pkg::SAMPLE_W-1:0]  quot;

    // Weights, clamped at ten tenths
    assign w_new = (weight > rmsf_pkg::WEIGHT_FULL) ? rmsf_pkg::WEIGHT_FULL : weight;
    assign w_old = rmsf_pkg::WEIGHT_FULL - w_new;

    // Weighted sum, then divide by ten through the reciprocal constant
    assign sum  = rmsf_pkg::SUM_W'(rmsf_pkg::SUM_W'(w_new) * rmsf_pkg::SUM_W'(median))
                + rmsf_pkg::SUM_W'(rmsf_pkg::SUM_W'(w_old) * rmsf_pkg::SUM_W'(smoothed));
    assign prod = (2*rmsf_pkg::SUM_W)'(sum) * (2*rmsf_pkg::SUM_W)'(rmsf_pkg::DIV10_MULT);
    assign quot = prod[rmsf_pkg::DIV10_SHIFT +: rmsf_pkg::SAMPLE_W];

    // A zero smoothed value is loaded with the median directly
    assign blended = (smoothed == '0) ? median : quot;
endmodule
